@@ hw/rtl/sor_pkg.sv @@
package sor_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int VAL_W   = 32;

    // Direction codes
    localparam logic CMD_UP   = 1'b0;
    localparam logic CMD_DOWN = 1'b1;

    // Request item
    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        start_position;
        logic signed [VAL_W-1:0] new_value;
    } sor_req_t;

    // Result item
    typedef struct packed {
        logic [IDX_W-1:0] final_position;
        logic [IDX_W-1:0] element_index;
    } sor_res_t;

endpackage

@@ hw/rtl/sorted_order_reposition_top.sv @@
// Channel   Handshake                 Payload
// request   start in / busy out       request (sor_req_t)
// result    done strobe out           result  (sor_res_t)
// config    cfg_valid / cfg_ready     cfg_data, active_count (5 bits)
//
// An item is taken when start is high and busy low; busy then rises.
// One neighbour compare (and swap) per cycle: an item moves one rank per swap until
// a compare finds no swap or the end of the active ranks is reached, and its result
// is strobed on done in the cycle after that terminating compare.
// A new item may be taken in the cycle that done is strobed.
// Reset restores zero values, identity order and active_count = ENTRIES.
// done lasts one cycle; the receiver cannot stall it.
module sorted_order_reposition_top
    import sor_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sor_req_t         request,
    output logic             done,
    output sor_res_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    typedef enum logic {
        IDLE,
        MOVE
    } state_t;

    state_t                  state_reg,  state_next;
    logic signed [VAL_W-1:0] vs_reg     [ENTRIES];
    logic signed [VAL_W-1:0] vs_next    [ENTRIES];
    logic [IDX_W-1:0]        r2e_reg    [ENTRIES];
    logic [IDX_W-1:0]        r2e_next   [ENTRIES];
    logic [IDX_W-1:0]        e2r_reg    [ENTRIES];
    logic [IDX_W-1:0]        e2r_next   [ENTRIES];
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [CNT_W-1:0]        n_reg,      n_next;
    logic                    cmd_reg,    cmd_next;
    logic [IDX_W-1:0]        pos_reg,    pos_next;
    logic [IDX_W-1:0]        elem_reg,   elem_next;
    logic signed [VAL_W-1:0] val_reg,    val_next;
    logic                    done_reg,   done_next;
    sor_res_t                result_reg, result_next;

    logic [IDX_W-1:0]        nb_rank;
    logic [IDX_W-1:0]        nb_elem;
    logic signed [VAL_W-1:0] nb_val;
    logic                    at_limit;
    logic                    do_swap;
    logic [IDX_W-1:0]        start_elem;

    assign busy      = (state_reg != IDLE);
    assign cfg_ready = ~busy;
    assign done      = done_reg;
    assign result    = result_reg;

    // Neighbour lookup and the shared compare
    always_comb
    begin
        nb_rank  = (cmd_reg == CMD_DOWN) ? pos_reg - IDX_W'(1) : pos_reg + IDX_W'(1);
        nb_elem  = r2e_reg[nb_rank];
        nb_val   = vs_reg[nb_elem];
        at_limit = (cmd_reg == CMD_DOWN) ? (pos_reg == '0)
                                         : ({1'b0, pos_reg} + CNT_W'(1) >= n_reg);
        do_swap  = ~at_limit && ((cmd_reg == CMD_DOWN) ? (nb_val > val_reg)
                                                       : (val_reg > nb_val));
        start_elem = r2e_reg[request.start_position];
    end

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        vs_next     = vs_reg;
        r2e_next    = r2e_reg;
        e2r_next    = e2r_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        elem_next   = elem_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    // write the new value and clamp the count
                    cmd_next             = request.command;
                    pos_next             = request.start_position;
                    val_next             = request.new_value;
                    elem_next            = start_elem;
                    vs_next[start_elem]  = request.new_value;
                    if (count_reg > CNT_W'(ENTRIES))
                        n_next = CNT_W'(ENTRIES);
                    else if (count_reg == '0)
                        n_next = CNT_W'(1);
                    else
                        n_next = count_reg;
                    state_next = MOVE;
                end
            end
            MOVE:
            begin
                if (do_swap)
                begin
                    r2e_next[pos_reg]  = nb_elem;
                    r2e_next[nb_rank]  = elem_reg;
                    e2r_next[elem_reg] = nb_rank;
                    e2r_next[nb_elem]  = pos_reg;
                    pos_next           = nb_rank;
                end
                else
                begin
                    done_next                  = 1'b1;
                    result_next.final_position = pos_reg;
                    result_next.element_index  = elem_reg;
                    state_next                 = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State, table and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            for (int i = 0; i < ENTRIES; i++)
            begin
                vs_reg[i]  <= '0;
                r2e_reg[i] <= IDX_W'(i);
                e2r_reg[i] <= IDX_W'(i);
            end
            count_reg  <= CNT_W'(ENTRIES);
            n_reg      <= CNT_W'(ENTRIES);
            cmd_reg    <= CMD_UP;
            pos_reg    <= '0;
            elem_reg   <= '0;
            val_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vs_reg     <= vs_next;
            r2e_reg    <= r2e_next;
            e2r_reg    <= e2r_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            cmd_reg    <= cmd_next;
            pos_reg    <= pos_next;
            elem_reg   <= elem_next;
            val_reg    <= val_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but sequencer not started");

    a_map_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r2e_reg[result.final_position] == result.element_index))
        else $error("rank map disagrees with result");

    a_map_inv: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (e2r_reg[result.element_index] == result.final_position))
        else $error("inverse map disagrees with result");

    a_up_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MOVE && cmd_reg == CMD_UP && pos_reg != request.start_position
         && $past(state_reg) == MOVE) |-> ({1'b0, pos_reg} < n_reg))
        else $error("upward move passed the active count");

endmodule

@@ sim/sorted_order_reposition_top_tb.sv @@
module sorted_order_reposition_top_tb;
    import sor_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = ENTRIES + 4;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    sor_req_t         request;
    logic             done;
    sor_res_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // Mirror of the block's table, permutation and register
    logic signed [VAL_W-1:0] stored_value [ENTRIES];
    logic [IDX_W-1:0]        order_of_rank [ENTRIES];
    logic [IDX_W-1:0]        rank_of_elem [ENTRIES];
    logic [CNT_W-1:0]        active_count_q;

    sor_res_t expected_places [$];
    int       mismatch_count;
    int       cycle_count;

    sorted_order_reposition_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock, 12 ns period
    always #6 clk = ~clk;

    // Run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Count as the block uses it: zero acts as one, above ENTRIES as ENTRIES
    function automatic int effective_count();
        int n;
        n = int'(active_count_q);
        if (n > ENTRIES)
            n = ENTRIES;
        if (n == 0)
            n = 1;
        return n;
    endfunction

    // Swap ranks r and r+1 when the lower one holds a strictly greater value
    function automatic bit swap_if_greater(input int r);
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        lo = order_of_rank[r];
        hi = order_of_rank[r + 1];
        if (!(stored_value[lo] > stored_value[hi]))
            return 1'b0;
        order_of_rank[r]     = hi;
        order_of_rank[r + 1] = lo;
        rank_of_elem[lo]     = IDX_W'(r + 1);
        rank_of_elem[hi]     = IDX_W'(r);
        return 1'b1;
    endfunction

    // Write the new value, then bubble the element to its sorted rank
    function automatic sor_res_t reposition_predict(input sor_req_t item);
        int               n;
        int               pos;
        logic [IDX_W-1:0] elem;
        sor_res_t         res;
        n = effective_count();
        pos = int'(item.start_position);
        elem = order_of_rank[pos];
        stored_value[elem] = item.new_value;
        if (item.command == CMD_UP)
        begin
            while (pos + 1 < n && swap_if_greater(pos))
                pos++;
        end
        else
        begin
            while (pos > 0 && swap_if_greater(pos - 1))
                pos--;
        end
        res.final_position = IDX_W'(pos);
        res.element_index  = elem;
        return res;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        sor_res_t want;
        if (rst_n && done)
        begin
            if (expected_places.size() == 0)
                report_mismatch("result with nothing outstanding", int'(result), 0);
            else
            begin
                want = expected_places.pop_front();
                if (result.final_position !== want.final_position)
                    report_mismatch("final_position", int'(result.final_position),
                                    int'(want.final_position));
                if (result.element_index !== want.element_index)
                    report_mismatch("element_index", int'(result.element_index),
                                    int'(want.element_index));
            end
        end
    end

    // Present one item and hold it until taken; start is left high
    task automatic send_item(input sor_req_t item);
        request <= item;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_places.push_back(reposition_predict(item));
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_places.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic set_active_count(input logic [CNT_W-1:0] count);
        drain_results();
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_count_q = count;
    endtask

    function automatic sor_req_t make_item(input logic command, input int pos,
                                           input logic signed [VAL_W-1:0] value);
        sor_req_t item;
        item.command        = command;
        item.start_position = IDX_W'(pos);
        item.new_value      = value;
        return item;
    endfunction

    // Random item: mostly in-range ranks and a direction that matches the change
    function automatic sor_req_t random_request();
        int                      pos;
        logic                    command;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] old_value;
        if ($urandom_range(0, 7) != 0)
            pos = $urandom_range(0, effective_count() - 1);
        else
            pos = $urandom_range(0, ENTRIES - 1);
        case ($urandom_range(0, 9))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            2, 3, 4: value = $signed(32'($urandom_range(0, 8))) - 32'sd4;
            default: value = $urandom;
        endcase
        old_value = stored_value[order_of_rank[pos]];
        if ($urandom_range(0, 3) == 0)
            command = $urandom_range(0, 1) ? CMD_DOWN : CMD_UP;
        else
            command = (value > old_value) ? CMD_UP : CMD_DOWN;
        return make_item(command, pos, value);
    endfunction

    // Extremes of value and rank on the reset table
    task automatic test_reset_order();
        send_item(make_item(CMD_UP,   0,  32'sd0));
        send_item(make_item(CMD_UP,   0,  32'sh7FFF_FFFF));
        send_item(make_item(CMD_DOWN, 15, 32'sh8000_0000));
        send_item(make_item(CMD_DOWN, 0,  32'sh8000_0000));
        idle_for(3);
        send_item(make_item(CMD_UP,   15, 32'sd1));
        send_item(make_item(CMD_DOWN, 8,  -32'sd1));
        send_item(make_item(CMD_UP,   7,  32'sd0));
    endtask

    // Register extremes: zero, one, above table size, start beyond count
    task automatic test_count_register();
        set_active_count(5'd0);
        send_item(make_item(CMD_UP,   3, 32'sd100));
        send_item(make_item(CMD_DOWN, 3, -32'sd100));
        set_active_count(5'd1);
        send_item(make_item(CMD_UP,   0, 32'sh7FFF_FFFE));
        set_active_count(5'd17);
        send_item(make_item(CMD_UP,   0, 32'sh7FFF_FFFE));
        set_active_count(5'd31);
        send_item(make_item(CMD_DOWN, 15, 32'sh8000_0000));
        set_active_count(5'd5);
        send_item(make_item(CMD_UP,   10, 32'sd50));
        send_item(make_item(CMD_UP,   4,  32'sd60));
        send_item(make_item(CMD_DOWN, 12, -32'sd50));
    endtask

    // Random items under one count, with bursts of sender idling
    task automatic test_random_phase(input logic [CNT_W-1:0] count, input int items);
        bit idle_on;
        set_active_count(count);
        idle_on = 1'b1;
        for (int i = 0; i < items; i++)
        begin
            if (i % 32 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (idle_on && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 13));
            send_item(random_request());
        end
    endtask

    // Sender holds off until every outstanding result is back
    task automatic test_drain_pause();
        for (int i = 0; i < 12; i++)
        begin
            send_item(random_request());
            if (i % 4 == 3)
                drain_results();
        end
    endtask

    // Back-to-back items, no idling
    task automatic test_back_to_back(input int items);
        set_active_count(5'd16);
        for (int i = 0; i < items; i++)
            send_item(random_request());
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        active_count_q = CNT_W'(ENTRIES);
        for (int i = 0; i < ENTRIES; i++)
        begin
            stored_value[i]  = '0;
            order_of_rank[i] = IDX_W'(i);
            rank_of_elem[i]  = IDX_W'(i);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_order();
        test_count_register();
        test_random_phase(5'd16, 210);
        test_drain_pause();
        test_random_phase(5'd2, 200);
        test_random_phase(5'd9, 210);
        test_random_phase(5'd1, 160);
        test_random_phase(5'd31, 200);
        test_random_phase(CNT_W'($urandom_range(1, 16)), 80);
        test_back_to_back(270);

        // Wait out the last results, then a little longer
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_places.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sor_pkg.sv
hw/rtl/sorted_order_reposition_top.sv
sim/sorted_order_reposition_top_tb.sv
